@@ rtl/core/wsd_pkg.sv @@
package wsd_pkg;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned CNT_W      = 4;

  localparam logic [6:0]       LEN7_EXT16 = 7'd126;
  localparam logic [6:0]       LEN7_EXT64 = 7'd127;
  localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
    logic              empty_frame;
  } res_t;

endpackage

@@ rtl/core/wsd_if.sv @@
interface wsd_in_if;
  import wsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  import wsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_of_frame;
  logic              empty_frame;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input last_of_frame,
                  input empty_frame, output ready);
endinterface

@@ rtl/core/wsd_parse.sv @@
module wsd_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [wsd_pkg::BYTE_W-1:0] rx_byte,
  output logic                      res_valid,
  output wsd_pkg::res_t             res
);
  import wsd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               mask_on_r, mask_on_nxt;
  logic [1:0]         idx_r, idx_nxt;

  logic               len_done;
  logic               hdr_done;
  logic [BYTE_W-1:0]  key_byte;
  logic [CNT_W-1:0]   cnt_dec;

  assign cnt_dec = cnt_r - 1'b1;

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    remain_nxt  = remain_r;
    key_nxt     = key_r;
    mask_on_nxt = mask_on_r;
    idx_nxt     = idx_r;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    if (take) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_on_nxt = rx_byte[7];
          remain_nxt  = '0;
          if (rx_byte[6:0] == LEN7_EXT16) begin
            phase_nxt = PH_EXTLEN;
            cnt_nxt   = EXT16_BYTES;
          end else if (rx_byte[6:0] == LEN7_EXT64) begin
            phase_nxt = PH_EXTLEN;
            cnt_nxt   = EXT64_BYTES;
          end else begin
            remain_nxt = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
            len_done   = 1'b1;
          end
        end
        PH_EXTLEN: begin
          remain_nxt = {remain_r[LEN_W-BYTE_W-1:0], rx_byte};
          cnt_nxt    = cnt_dec;
          len_done   = (cnt_dec == '0);
        end
        PH_MASK: begin
          key_nxt  = {key_r[KEY_W-BYTE_W-1:0], rx_byte};
          cnt_nxt  = cnt_dec;
          hdr_done = (cnt_dec == '0);
        end
        PH_PAYLOAD: begin
          idx_nxt    = idx_r + 1'b1;
          remain_nxt = remain_r - 1'b1;
          res_valid  = 1'b1;
          res.payload_byte  = mask_on_r ? (rx_byte ^ key_byte) : rx_byte;
          res.last_of_frame = (remain_r == {{(LEN_W-1){1'b0}}, 1'b1});
          res.empty_frame   = 1'b0;
          if (res.last_of_frame) phase_nxt = PH_HDR0;
        end
        default: begin
          // first header byte: FIN and opcode dropped
          phase_nxt = PH_HDR1;
          cnt_nxt   = '0;
        end
      endcase

      if (len_done) begin
        if (mask_on_nxt) begin
          phase_nxt = PH_MASK;
          cnt_nxt   = KEY_BYTES;
          key_nxt   = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        idx_nxt = '0;
        if (remain_nxt == '0) begin
          phase_nxt         = PH_HDR0;
          res_valid         = 1'b1;
          res.payload_byte  = '0;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      cnt_r     <= '0;
      mask_on_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      mask_on_r <= mask_on_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // length and key are always reloaded before use
  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    key_r    <= key_nxt;
  end

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// Channel   | Dir | Payload                                        | Handshake
// in_chan   | in  | rx_byte[7:0]                                   | valid/ready
// out_chan  | out | payload_byte[7:0], last_of_frame, empty_frame  | valid/ready
//
// One byte per clock sustained while out_chan accepts; each byte is parsed in the
// cycle it is taken and its result (if any) is registered in the output register or,
// while the output stalls, in the skid. Synchronous active-low reset returns the
// parser to the first header byte. A skid register behind the output register holds
// one more result during an output stall; in_chan.ready drops only while the skid holds an item.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_chan,
  wsd_out_if.source  out_chan
);
  import wsd_pkg::*;

  logic  take;
  logic  res_valid;
  res_t  res;

  // output register and skid stage
  logic  out_v_r, out_v_nxt;
  res_t  out_r, out_nxt;
  logic  skid_v_r, skid_v_nxt;
  res_t  skid_r, skid_nxt;
  logic  out_pop;

  assign in_chan.ready = !skid_v_r;
  assign take          = in_chan.valid && in_chan.ready;
  assign out_pop       = out_v_r && out_chan.ready;

  wsd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_chan.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      // input is held off; drain skid into output
      if (out_pop) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_r || out_pop) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.payload_byte  = out_r.payload_byte;
  assign out_chan.last_of_frame = out_r.last_of_frame;
  assign out_chan.empty_frame   = out_r.empty_frame;

endmodule
